// ===== design/iir_bandpass_decimator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// IIR band-pass decimator assertion macros
// Shared concurrent assertion wrappers for the modules of the decimator.
// ----------------------------------------------------------------------------
`ifndef IIR_BANDPASS_DECIMATOR_UNIT_DEFINES_SVH
`define IIR_BANDPASS_DECIMATOR_UNIT_DEFINES_SVH

// Checked on every rising edge while out of reset.
`define IIRBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IIRBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/iirbd_pkg.sv =====
// ----------------------------------------------------------------------------
// IIR band-pass decimator package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package iirbd_pkg;

  localparam int unsigned COEF_SHIFT  = 10;
  localparam int unsigned ACC_WIDTH   = 32;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned RESULT_W    = 32;
  localparam int unsigned POLE_ONE_W  = 12;
  localparam int unsigned POLE_TWO_W  = 10;
  localparam int unsigned EQ_COEF_W   = 10;
  localparam int unsigned DECIM_W     = 7;
  localparam int unsigned PHASE_W     = 6;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned DECIM_MAX   = 64;

  // Product widths: a signed coefficient times an accumulator value.
  localparam int unsigned PROD_ONE_W  = POLE_ONE_W + ACC_WIDTH;
  localparam int unsigned PROD_TWO_W  = POLE_TWO_W + 1 + ACC_WIDTH;
  localparam int unsigned PROD_EQ_W   = EQ_COEF_W + 1 + ACC_WIDTH;

  typedef logic        [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [RESULT_W-1:0]   result_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;
  typedef logic        [PHASE_W-1:0]    phase_t;
  typedef logic        [DECIM_W-1:0]    decim_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  localparam logic signed [POLE_ONE_W-1:0] POLE_ONE_RST = POLE_ONE_W'(1204);
  localparam logic [POLE_TWO_W-1:0]        POLE_TWO_RST = POLE_TWO_W'(1023);
  localparam logic [EQ_COEF_W-1:0]         EQ_COEF_RST  = EQ_COEF_W'(979);
  localparam decim_t                       DECIM_RST    = DECIM_W'(40);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLE_COEF_ONE     = 2'd0,
    CFG_POLE_COEF_TWO     = 2'd1,
    CFG_EQ_COEF           = 2'd2,
    CFG_DECIMATION_FACTOR = 2'd3
  } cfg_idx_e;

  // Coefficients as seen by the filter core; decim is already clamped to 1..64.
  typedef struct packed {
    logic signed [POLE_ONE_W-1:0] pole_coef_one;
    logic [POLE_TWO_W-1:0]        pole_coef_two;
    logic [EQ_COEF_W-1:0]         eq_coef;
    decim_t                       decim;
  } cfg_t;

  // Handshake between the stage control and the filter core.
  typedef struct packed {
    logic fire;
  } core_ctrl_t;

  typedef struct packed {
    logic emit;
  } core_stat_t;

endpackage

// ===== design/iirbd_sample_if.sv =====
// ----------------------------------------------------------------------------
// IIR band-pass decimator input channel
// Valid/ready channel carrying one raw converter sample per beat.
// ----------------------------------------------------------------------------
interface iirbd_sample_if;
  import iirbd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== design/iirbd_result_if.sv =====
// ----------------------------------------------------------------------------
// IIR band-pass decimator output channel
// Valid/ready channel carrying one equalised decimated sample per beat.
// ----------------------------------------------------------------------------
interface iirbd_result_if;
  import iirbd_pkg::*;

  logic    valid;
  logic    ready;
  result_t tuned_sample;

  modport source (output valid, output tuned_sample, input ready);
  modport sink   (input valid, input tuned_sample, output ready);
endinterface

// ===== design/iirbd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// IIR band-pass decimator configuration registers
// Write-only register file holding the coefficients and decimation factor.
// ----------------------------------------------------------------------------
module iirbd_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  iirbd_pkg::cfg_idx_e       cfg_idx_i,
  input  iirbd_pkg::cfg_data_t      cfg_data_i,
  output iirbd_pkg::cfg_t           cfg_o
);
  import iirbd_pkg::*;

  logic signed [POLE_ONE_W-1:0] pole_one_q;
  logic [POLE_TWO_W-1:0]        pole_two_q;
  logic [EQ_COEF_W-1:0]         eq_coef_q;
  decim_t                       decim_q;
  decim_t                       decim_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_one_q <= POLE_ONE_RST;
      pole_two_q <= POLE_TWO_RST;
      eq_coef_q  <= EQ_COEF_RST;
      decim_q    <= DECIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLE_COEF_ONE:     pole_one_q <= $signed(cfg_data_i[POLE_ONE_W-1:0]);
        CFG_POLE_COEF_TWO:     pole_two_q <= cfg_data_i[POLE_TWO_W-1:0];
        CFG_EQ_COEF:           eq_coef_q  <= cfg_data_i[EQ_COEF_W-1:0];
        CFG_DECIMATION_FACTOR: decim_q    <= cfg_data_i[DECIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A factor of zero behaves as one; anything above the maximum saturates.
  always_comb begin
    if (decim_q == '0) begin
      decim_clamped = DECIM_W'(1);
    end else if (decim_q > DECIM_W'(DECIM_MAX)) begin
      decim_clamped = DECIM_W'(DECIM_MAX);
    end else begin
      decim_clamped = decim_q;
    end
  end

  assign cfg_o = '{
    pole_coef_one: pole_one_q,
    pole_coef_two: pole_two_q,
    eq_coef:       eq_coef_q,
    decim:         decim_clamped
  };

endmodule

// ===== design/iirbd_core.sv =====
// ----------------------------------------------------------------------------
// IIR band-pass decimator filter core
// Resonator recursion, decimation phase and two-tap equaliser, one sample per fire.
// ----------------------------------------------------------------------------
`include "iir_bandpass_decimator_unit_defines.svh"

module iirbd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iirbd_pkg::cfg_t       cfg_i,
  input  iirbd_pkg::core_ctrl_t ctrl_i,
  input  iirbd_pkg::sample_t    sample_i,
  output iirbd_pkg::core_stat_t stat_o,
  output iirbd_pkg::result_t    result_o
);
  import iirbd_pkg::*;

  acc_t   iir_prev_one_q, iir_prev_one_d;
  acc_t   iir_prev_two_q, iir_prev_two_d;
  acc_t   eq_prev_one_q,  eq_prev_one_d;
  acc_t   eq_prev_two_q,  eq_prev_two_d;
  phase_t phase_q,        phase_d;

  logic signed [PROD_ONE_W-1:0] prod_one, shift_one;
  logic signed [PROD_TWO_W-1:0] prod_two, shift_two;
  logic signed [PROD_EQ_W-1:0]  prod_eq,  shift_eq;
  logic [DECIM_W-1:0]           phase_inc;
  acc_t                         iir_out;
  acc_t                         eq_out;
  logic                         emit;

  // Full-width products; the arithmetic shift gives the floor of the division.
  assign prod_one  = cfg_i.pole_coef_one * iir_prev_one_q;
  assign prod_two  = $signed({1'b0, cfg_i.pole_coef_two}) * iir_prev_two_q;
  assign prod_eq   = $signed({1'b0, cfg_i.eq_coef}) * eq_prev_two_q;
  assign shift_one = prod_one >>> COEF_SHIFT;
  assign shift_two = prod_two >>> COEF_SHIFT;
  assign shift_eq  = prod_eq  >>> COEF_SHIFT;

  // Only the low accumulator bits survive the wrap, so add at that width.
  assign iir_out = acc_t'(ACC_WIDTH'(sample_i)) - shift_one[ACC_WIDTH-1:0]
                   - shift_two[ACC_WIDTH-1:0];
  assign eq_out  = iir_out + shift_eq[ACC_WIDTH-1:0];

  assign phase_inc = DECIM_W'(phase_q) + DECIM_W'(1);
  assign emit      = (phase_inc >= cfg_i.decim);

  always_comb begin
    iir_prev_one_d = iir_prev_one_q;
    iir_prev_two_d = iir_prev_two_q;
    eq_prev_one_d  = eq_prev_one_q;
    eq_prev_two_d  = eq_prev_two_q;
    phase_d        = phase_q;
    if (ctrl_i.fire) begin
      iir_prev_one_d = iir_out;
      iir_prev_two_d = iir_prev_one_q;
      if (emit) begin
        phase_d       = '0;
        eq_prev_one_d = iir_out;
        eq_prev_two_d = eq_prev_one_q;
      end else begin
        phase_d = phase_inc[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iir_prev_one_q <= '0;
      iir_prev_two_q <= '0;
      eq_prev_one_q  <= '0;
      eq_prev_two_q  <= '0;
      phase_q        <= '0;
    end else begin
      iir_prev_one_q <= iir_prev_one_d;
      iir_prev_two_q <= iir_prev_two_d;
      eq_prev_one_q  <= eq_prev_one_d;
      eq_prev_two_q  <= eq_prev_two_d;
      phase_q        <= phase_d;
    end
  end

  assign stat_o   = '{emit: emit};
  assign result_o = result_t'(eq_out);

  `IIRBD_ASSERT(a_phase_restart, ctrl_i.fire && emit |=> phase_q == '0,
    "Phase did not restart after an emitting sample")
  `IIRBD_ASSERT(a_idle_holds, !ctrl_i.fire |=> $stable(iir_prev_one_q) && $stable(phase_q)
    && $stable(eq_prev_one_q), "Filter state moved without a sample")
  `IIRBD_ASSERT(a_eq_tracks_iir, ctrl_i.fire && emit |=> eq_prev_one_q == iir_prev_one_q,
    "Equaliser history out of step with the resonator")

endmodule

// ===== design/iir_bandpass_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// IIR band-pass decimator unit
// Two-pole resonator, decimator and two-tap equaliser behind valid/ready channels.
// ----------------------------------------------------------------------------
//   Channel    Direction  Payload                 Beat
//   adc_in     sink       adc_sample   16b uns    one raw converter sample
//   tuned_out  source     tuned_sample 32b signed one result per decimation period
//   cfg        write      12b data, 2b index      one register write
//
// A sample is captured in the input register, processed by the core from there
// and, when it closes a decimation period, lands in the output register. One
// sample is taken per cycle while no result stalls the input register, set by the
// resonator recursion (two multiplies and adds on the fed-back state).
// A full output register stalls only a sample that produces a result.
// Reset clears the filter histories and phase and loads the default coefficients.
// ----------------------------------------------------------------------------
`include "iir_bandpass_decimator_unit_defines.svh"

module iir_bandpass_decimator_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  iirbd_sample_if.sink          adc_in,
  iirbd_result_if.source        tuned_out,
  input  logic                  cfg_we_i,
  input  iirbd_pkg::cfg_idx_e   cfg_idx_i,
  input  iirbd_pkg::cfg_data_t  cfg_data_i
);
  import iirbd_pkg::*;

  cfg_t       cfg;
  core_ctrl_t core_ctrl;
  core_stat_t core_stat;
  result_t    core_result;

  logic    in_valid_q, in_valid_d;
  sample_t in_sample_q;
  logic    out_valid_q, out_valid_d;
  result_t out_data_q;

  logic in_accept;
  logic out_free;
  logic consume;

  iirbd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  iirbd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .ctrl_i   (core_ctrl),
    .sample_i (in_sample_q),
    .stat_o   (core_stat),
    .result_o (core_result)
  );

  // A sample that yields no result never waits on the output side.
  assign out_free       = !out_valid_q || tuned_out.ready;
  assign consume        = in_valid_q && (!core_stat.emit || out_free);
  assign core_ctrl      = '{fire: consume};
  assign adc_in.ready   = !in_valid_q || consume;
  assign in_accept      = adc_in.valid && adc_in.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (consume && core_stat.emit) begin
      out_valid_d = 1'b1;
    end else if (tuned_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_sample_q <= adc_in.adc_sample;
    end
    if (consume && core_stat.emit) begin
      out_data_q <= core_result;
    end
  end

  assign tuned_out.valid        = out_valid_q;
  assign tuned_out.tuned_sample = out_data_q;

  `IIRBD_ASSERT(a_no_overwrite, out_valid_q && !tuned_out.ready |-> !(consume && core_stat.emit),
    "Result register overwritten before its beat was taken")
  `IIRBD_ASSERT(a_stall_blocks_input, in_valid_q && !consume |-> !adc_in.ready,
    "Input taken while the held sample was stalled")
  `IIRBD_ASSERT_ALWAYS(a_fire_needs_sample, consume |-> in_valid_q,
    "Filter fired without a held sample")

endmodule

// ===== tb/iir_bandpass_decimator_unit_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IIR band-pass decimator result checker
// Watches the sample, result and register ports, keeps its own copy of the
// resonator, decimator and equaliser state, and compares every result beat
// with the oldest predicted tuned sample.
// ----------------------------------------------------------------------------
module iir_bandpass_decimator_unit_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  iirbd_sample_if              adc_mon,
  iirbd_result_if              tuned_mon,
  input  logic                 cfg_we_i,
  input  iirbd_pkg::cfg_idx_e  cfg_idx_i,
  input  iirbd_pkg::cfg_data_t cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          outstanding_o
);
  import iirbd_pkg::*;

  logic signed [POLE_ONE_W-1:0] pole_one;
  logic [POLE_TWO_W-1:0]        pole_two;
  logic [EQ_COEF_W-1:0]         eq_tap;
  decim_t                       decim;

  acc_t   res_prev_one;
  acc_t   res_prev_two;
  acc_t   dec_prev_one;
  acc_t   dec_prev_two;
  phase_t phase;

  result_t     pending_tuned[$];
  int unsigned fails;

  // One sample through the resonator; closes the period when the phase reaches
  // the clamped factor and queues the equalised sample.
  task automatic advance_resonator(input sample_t x);
    longint      fb_one;
    longint      fb_two;
    longint      eq_term;
    acc_t        y;
    int unsigned span;
    if (decim == '0) begin
      span = 1;
    end else if (decim > DECIM_MAX) begin
      span = DECIM_MAX;
    end else begin
      span = decim;
    end
    fb_one = longint'(pole_one) * longint'(res_prev_one);
    fb_two = longint'(pole_two) * longint'(res_prev_two);
    y = acc_t'(longint'(x) - (fb_one >>> COEF_SHIFT) - (fb_two >>> COEF_SHIFT));
    res_prev_two = res_prev_one;
    res_prev_one = y;
    if (int'(phase) + 1 >= int'(span)) begin
      phase = '0;
      eq_term = longint'(eq_tap) * longint'(dec_prev_two);
      pending_tuned.push_back(result_t'(longint'(y) + (eq_term >>> COEF_SHIFT)));
      dec_prev_two = dec_prev_one;
      dec_prev_one = y;
    end else begin
      phase = phase + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      pole_one     = POLE_ONE_RST;
      pole_two     = POLE_TWO_RST;
      eq_tap       = EQ_COEF_RST;
      decim        = DECIM_RST;
      res_prev_one = '0;
      res_prev_two = '0;
      dec_prev_one = '0;
      dec_prev_two = '0;
      phase        = '0;
      pending_tuned.delete();
      fails        = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLE_COEF_ONE:     pole_one = cfg_data_i[POLE_ONE_W-1:0];
          CFG_POLE_COEF_TWO:     pole_two = cfg_data_i[POLE_TWO_W-1:0];
          CFG_EQ_COEF:           eq_tap   = cfg_data_i[EQ_COEF_W-1:0];
          CFG_DECIMATION_FACTOR: decim    = cfg_data_i[DECIM_W-1:0];
        endcase
      end
      // The result beat is checked before this edge's sample is predicted, so a
      // stray result can never be matched against a fresh expectation.
      if (tuned_mon.valid && tuned_mon.ready) begin
        if (pending_tuned.size() == 0) begin
          fails++;
          $display("%0t: tuned_sample expected none, got %0d", $time,
                   tuned_mon.tuned_sample);
        end else begin
          want = pending_tuned.pop_front();
          if (want !== tuned_mon.tuned_sample) begin
            fails++;
            $display("%0t: tuned_sample expected %0d, got %0d", $time, want,
                     tuned_mon.tuned_sample);
          end
        end
      end
      if (adc_mon.valid && adc_mon.ready) begin
        advance_resonator(adc_mon.adc_sample);
      end
      fail_count_o  <= fails;
      outstanding_o <= pending_tuned.size();
    end
  end

endmodule

// ===== tb/iir_bandpass_decimator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IIR band-pass decimator unit testbench
// Drives converter samples and register writes into the decimator, pulls the
// tuned samples out with random back-pressure, and leaves the comparison to
// the result checker. Directed overflow and factor corner cases come first,
// then randomised register settings and sample streams.
// ----------------------------------------------------------------------------
module iir_bandpass_decimator_unit_test;
  import iirbd_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1700;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_LIMIT   = 5000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_idx_e  cfg_idx_i;
  cfg_data_t cfg_data_i;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned sent;
  int unsigned quiet_cycles;
  bit          sender_calm;
  bit          receiver_calm;
  bit          hold_req;

  iirbd_sample_if adc_if ();
  iirbd_result_if tuned_if ();

  iir_bandpass_decimator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adc_in     (adc_if),
    .tuned_out  (tuned_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  iir_bandpass_decimator_unit_check tuning_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adc_mon       (adc_if),
    .tuned_mon     (tuned_if),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Ends the run if no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((adc_if.valid && adc_if.ready) || (tuned_if.valid && tuned_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: a random hold before each beat, and one long hold on request.
  initial begin : receiver
    int unsigned stall;
    tuned_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        tuned_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = receiver_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        tuned_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      tuned_if.ready <= 1'b1;
      do @(posedge clk_i); while (!tuned_if.valid);
    end
  end

  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      adc_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    adc_if.valid      <= 1'b1;
    adc_if.adc_sample <= s;
    do @(posedge clk_i); while (!adc_if.ready);
    sent++;
  endtask

  // Stops offering samples and waits until every queued tuned sample is out
  // and the last sample has left the pipeline.
  task automatic wait_for_results();
    adc_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic cfg_write(input cfg_idx_e idx, input cfg_data_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_filter(input cfg_data_t a1, input cfg_data_t a2,
                                input cfg_data_t c, input cfg_data_t d);
    cfg_write(CFG_POLE_COEF_ONE, a1);
    cfg_write(CFG_POLE_COEF_TWO, a2);
    cfg_write(CFG_EQ_COEF, c);
    cfg_write(CFG_DECIMATION_FACTOR, d);
    cfg_we_i <= 1'b0;
  endtask

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return sample_t'($urandom_range(0, 255));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic cfg_data_t draw_tap();
    case ($urandom_range(0, 5))
      0:       return {2'($urandom), 10'h000};
      1:       return {2'($urandom), 10'h3FF};
      default: return cfg_data_t'($urandom);
    endcase
  endfunction

  // Picks a register setting, mostly short periods, and returns the factor
  // that the block will actually use. Unused upper data bits are random.
  task automatic random_setting(output int unsigned span);
    cfg_data_t   a1;
    cfg_data_t   d;
    int unsigned dval;
    case ($urandom_range(0, 5))
      0:       a1 = 12'h800;
      1:       a1 = 12'h7FF;
      default: a1 = cfg_data_t'($urandom);
    endcase
    case ($urandom_range(0, 11))
      0, 1, 2, 3: dval = $urandom_range(1, 4);
      4, 5, 6, 7: dval = $urandom_range(5, 16);
      8:          dval = $urandom_range(17, 64);
      9:          dval = 0;
      10:         dval = $urandom_range(65, 127);
      default:    dval = DECIM_MAX;
    endcase
    d = {5'($urandom), 7'(dval)};
    if (dval == 0) begin
      span = 1;
    end else if (dval > DECIM_MAX) begin
      span = DECIM_MAX;
    end else begin
      span = dval;
    end
    // Now and then only the factor changes, which may cut a period short.
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CFG_DECIMATION_FACTOR, d);
      cfg_we_i <= 1'b0;
    end else begin
      program_filter(a1, draw_tap(), draw_tap(), d);
    end
  endtask

  initial begin : stimulus
    int unsigned span;
    int unsigned count;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_POLE_COEF_ONE;
    cfg_data_i        <= '0;
    adc_if.valid      <= 1'b0;
    adc_if.adc_sample <= '0;
    sent          = 0;
    quiet_cycles  = 0;
    hold_req      = 1'b0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients, then a factor lowered to the phase already
    // reached, so the very next sample closes the period.
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    wait_for_results();
    cfg_write(CFG_DECIMATION_FACTOR, 12'd2);
    cfg_we_i <= 1'b0;
    send_sample(16'h8000);
    wait_for_results();

    // Strong positive feedback with a factor of zero: every sample emits and
    // the state runs past the accumulator range and wraps.
    program_filter(12'h800, 12'hC00, 12'hFFF, 12'h000);
    repeat (16) send_sample(16'hFFFF);
    wait_for_results();

    // Largest positive first coefficient, full second pole, no equaliser tap;
    // the factor's upper data bits are ignored.
    program_filter(12'h7FF, 12'h3FF, 12'h000, 12'hF81);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0001);
    send_sample(16'hFFFE);
    wait_for_results();

    // Long hold on the result side while samples keep coming: the output
    // register fills and the input stalls.
    sender_calm = 1'b1;
    cfg_write(CFG_DECIMATION_FACTOR, 12'd1);
    cfg_we_i <= 1'b0;
    hold_req = 1'b1;
    repeat (40) send_sample(draw_sample());
    wait_for_results();

    while (sent < ITEM_TARGET) begin
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      random_setting(span);
      count = span * $urandom_range(1, 5) + $urandom_range(0, span - 1);
      repeat (count) send_sample(draw_sample());
      wait_for_results();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/iirbd_pkg.sv
design/iirbd_sample_if.sv
design/iirbd_result_if.sv
design/iirbd_cfg_regs.sv
design/iirbd_core.sv
design/iir_bandpass_decimator_unit.sv
tb/iir_bandpass_decimator_unit_check.sv
tb/iir_bandpass_decimator_unit_test.sv
